>>> rtl/mfap_pkg.sv
`timescale 1ns / 1ps
package mfap_pkg;
  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_EDGES_DEF = 256;
  localparam int CAP_BITS_DEF = 16;
  localparam int FLOW_BITS = 24;
  localparam logic [FLOW_BITS-1:0] FLOW_MAX = 24'hFFFFFF;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_RUN = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load_fwd;    // write forward arc (first beat of a load)
    logic add_rev;     // write reverse arc
    logic clear;       // empty arc store
    logic bfs_init;    // start a search
    logic pop;         // take next queue entry
    logic fetch;       // load dequeued vertex
    logic scan;        // issue read of current arc
    logic visit;       // evaluate arc read last cycle
    logic walk_init;   // start path walk at sink
    logic walk_rd;     // read parent arc
    logic walk_eval;   // fold arc into bottleneck
    logic upd_rd;      // read arc pair for update
    logic upd_wr;      // write arc pair back
    logic flow_clr;    // zero flow sum
    logic flow_add;    // add bottleneck to sum
  } mfap_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic q_empty;
    logic u_is_sink;
    logic scan_done;
    logic sink_found;
    logic walk_at_src;
    logic walk_bad;
    logic add_range;
    logic add_full;
  } mfap_sts_t;
endpackage

>>> rtl/max_flow_augmenting_path.sv
`timescale 1ns / 1ps
// Max flow by repeated breadth-first augmenting paths. One item is worked at a
// time and each gives one result beat, which must be taken before the next
// item is accepted. An edge load writes the forward arc in its accept cycle
// and the reverse arc in the next, with the result offered in that next cycle;
// clear and the spare code offer their result in the cycle after accept. A run
// stalls far longer, as the arc store is read one registered arc at a time:
// each search has a start state, then for each dequeued vertex a pop, a fetch
// and a scan and visit per stored arc (stopping at the sink); each path found
// then takes a bottleneck walk and an update walk over its arcs and an add to
// the flow sum, and the run ends with a done state before its result beat.
module max_flow_augmenting_path import mfap_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF,
  parameter int CAP_BITS = CAP_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // operation, from_vertex, to_vertex, capacity
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // status, total_flow
);
  logic [6:0] vert_limit;
  mfap_cmd_t cmd;
  mfap_sts_t sts;
  logic [1:0] status;
  logic use_flow;
  logic [FLOW_BITS-1:0] flow;

  always_ff @(posedge clk) begin
    if (rst) vert_limit <= 7'd64;
    else if (cfg_we) vert_limit <= cfg_wdata;
  end

  mfap_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .op(s_axis_tdata[1:0]),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .status, .use_flow, .sts, .cmd
  );

  mfap_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES),
                  .CAP_BITS(CAP_BITS)) u_dp (
    .clk, .rst, .cmd, .sts, .vert_limit,
    .from_vertex(s_axis_tdata[7:2]), .to_vertex(s_axis_tdata[13:8]),
    .capacity(s_axis_tdata[29:14]), .flow
  );

  assign m_axis_tdata = {6'd0, (use_flow ? flow : {FLOW_BITS{1'b0}}), status};
endmodule

>>> rtl/mfap_datapath.sv
`timescale 1ns / 1ps
module mfap_datapath import mfap_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF,
  parameter int CAP_BITS = CAP_BITS_DEF,
  localparam int VW = $clog2(MAX_VERTICES),
  localparam int SLOTS = 2 * MAX_EDGES,
  localparam int AW = $clog2(SLOTS),
  localparam int CW = AW + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mfap_cmd_t            cmd,
  output mfap_sts_t            sts,
  input  logic [6:0]           vert_limit,
  input  logic [5:0]           from_vertex,
  input  logic [5:0]           to_vertex,
  input  logic [15:0]          capacity,
  output logic [FLOW_BITS-1:0] flow
);
  localparam int NW = VW + 1;

  // Arc store: ends (tail in the upper half, head in the lower) and residuals
  logic [2*VW-1:0]     ends_mem [SLOTS];
  logic [CAP_BITS-1:0] res_mem  [SLOTS];
  logic [VW-1:0]       queue_mem [MAX_VERTICES];
  logic [AW:0]         parent_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] visited;

  logic [CW-1:0] arc_total;
  logic [CW-1:0] scan_idx;
  logic [NW-1:0] q_head, q_tail;
  logic [VW-1:0] cur_u, walk_v, walk_v_next;
  logic [NW-1:0] steps;
  logic [CAP_BITS-1:0] neck;
  logic          neck_set;
  logic [AW-1:0] rd_addr;
  logic [2*VW-1:0] rd_ends;
  logic [CAP_BITS-1:0] rd_res, rd_res_pair;
  logic [AW-1:0] upd_arc;
  logic [NW-1:0] n_eff;
  logic [VW-1:0] sink;
  logic [VW-1:0] q_rd;
  logic [AW:0]   par_q;
  logic          f_ok, t_ok;
  logic [VW-1:0] fv, tv, arc_to;
  logic [2*VW-1:0] rev_ends;
  logic [CAP_BITS-1:0] cap_in;
  logic          hit;
  logic [FLOW_BITS:0] sum;

  // Effective vertex count clamped to [2, MAX_VERTICES]
  always_comb begin
    if (vert_limit < 7'd2) n_eff = NW'(2);
    else if (32'(vert_limit) > MAX_VERTICES) n_eff = NW'(MAX_VERTICES);
    else n_eff = NW'(vert_limit);
  end
  assign sink = VW'(n_eff - NW'(1));
  assign f_ok = (32'(from_vertex) < 32'(n_eff));
  assign t_ok = (32'(to_vertex) < 32'(n_eff));
  assign fv = VW'(from_vertex);
  assign tv = VW'(to_vertex);
  assign cap_in = CAP_BITS'(capacity);
  assign arc_to = rd_ends[VW-1:0];

  assign sts.add_range   = !(f_ok && t_ok);
  assign sts.add_full    = (32'(arc_total) + 2 > SLOTS);
  assign sts.q_empty     = (q_head >= q_tail);
  assign sts.u_is_sink   = (cur_u == sink);
  assign sts.scan_done   = (scan_idx >= arc_total);
  assign sts.sink_found  = visited[sink];
  assign sts.walk_at_src = (walk_v == '0);
  assign sts.walk_bad    = par_q[AW] || (steps >= n_eff);

  // Arc store writes; hold the reverse ends for the reverse arc write
  always_ff @(posedge clk) begin
    if (cmd.load_fwd) begin
      ends_mem[arc_total[AW-1:0]] <= {fv, tv};
      res_mem[arc_total[AW-1:0]]  <= cap_in;
      rev_ends                    <= {tv, fv};
    end else if (cmd.add_rev) begin
      ends_mem[arc_total[AW-1:0]] <= rev_ends;
      res_mem[arc_total[AW-1:0]]  <= '0;
    end else if (cmd.upd_wr) begin
      res_mem[upd_arc]          <= rd_res - neck;
      res_mem[upd_arc ^ AW'(1)] <= rd_res_pair + neck;
    end
  end

  // Registered reads of the arc store
  always_comb begin
    if (cmd.scan) rd_addr = scan_idx[AW-1:0];
    else rd_addr = par_q[AW-1:0];
  end
  always_ff @(posedge clk) begin
    rd_ends     <= ends_mem[rd_addr];
    rd_res      <= res_mem[rd_addr];
    rd_res_pair <= res_mem[rd_addr ^ AW'(1)];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) arc_total <= '0;
    else if (cmd.load_fwd || cmd.add_rev) arc_total <= arc_total + CW'(1);
  end

  // Registered reads of the queue head and the parent of the next walk vertex
  always_ff @(posedge clk) begin
    q_rd  <= queue_mem[q_head[VW-1:0]];
    par_q <= parent_mem[walk_v_next];
  end

  // A scanned arc leaves the current vertex towards an unvisited one with residual
  assign hit = cmd.visit && 32'(arc_to) < 32'(n_eff) && rd_ends[2*VW-1:VW] == cur_u &&
               rd_res != '0 && !visited[arc_to];

  // Search scratch: queue and parent arcs
  always_ff @(posedge clk) begin
    if (cmd.bfs_init) begin
      queue_mem[0] <= '0;
    end else if (hit && 32'(q_tail) < MAX_VERTICES) begin
      queue_mem[q_tail[VW-1:0]] <= arc_to;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) parent_mem[arc_to] <= {1'b0, scan_idx[AW-1:0] - AW'(1)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visited  <= '0;
      q_head   <= '0;
      q_tail   <= '0;
      scan_idx <= '0;
      cur_u    <= '0;
    end else begin
      if (cmd.bfs_init) begin
        visited    <= '0;
        visited[0] <= 1'b1;
        q_head     <= '0;
        q_tail     <= NW'(1);
      end
      if (cmd.pop) begin
        q_head   <= q_head + NW'(1);
        scan_idx <= '0;
      end
      if (cmd.fetch) cur_u <= q_rd;
      if (cmd.scan) scan_idx <= scan_idx + CW'(1);
      if (hit) begin
        visited[arc_to] <= 1'b1;
        if (32'(q_tail) < MAX_VERTICES) q_tail <= q_tail + NW'(1);
      end
    end
  end

  // Path walk: bottleneck pass then update pass, stepping to each arc's tail
  always_comb begin
    walk_v_next = walk_v;
    if (cmd.walk_init) walk_v_next = sink;
    else if (cmd.walk_eval || cmd.upd_wr) walk_v_next = rd_ends[2*VW-1:VW];
  end

  always_ff @(posedge clk) begin
    walk_v <= walk_v_next;
    if (cmd.walk_init) begin
      steps    <= '0;
      neck_set <= 1'b0;
    end
    if (cmd.upd_rd) upd_arc <= par_q[AW-1:0];
    if (cmd.walk_eval) begin
      if (!neck_set || rd_res < neck) neck <= rd_res;
      neck_set <= 1'b1;
      steps    <= steps + NW'(1);
    end
  end

  // Flow sum, saturating
  assign sum = {1'b0, flow} + (FLOW_BITS+1)'(neck);
  always_ff @(posedge clk) begin
    if (rst || cmd.flow_clr) flow <= '0;
    else if (cmd.flow_add) flow <= sum[FLOW_BITS] ? FLOW_MAX : sum[FLOW_BITS-1:0];
  end
endmodule

>>> rtl/mfap_ctrl.sv
`timescale 1ns / 1ps
module mfap_ctrl import mfap_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           op,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic                 use_flow,
  input  mfap_sts_t            sts,
  output mfap_cmd_t            cmd
);
  localparam logic [3:0] S_IDLE = 4'd0, S_REV = 4'd1, S_BFS = 4'd2, S_POP = 4'd3,
                         S_SCAN = 4'd4, S_VIS = 4'd5, S_WINIT = 4'd6, S_WRD = 4'd7,
                         S_WEV = 4'd8, S_UINIT = 4'd9, S_URD = 4'd10, S_UWR = 4'd11,
                         S_ADD = 4'd12, S_DONE = 4'd13, S_FETCH = 4'd14;
  logic [3:0] state, state_next;
  logic       take;
  logic       res_pending;

  assign in_ready = (state == S_IDLE) && !res_pending;
  assign take = in_valid && in_ready;
  assign out_valid = res_pending;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take) begin
          if (op == OP_ADD && !sts.add_range && !sts.add_full) begin
            cmd.load_fwd = 1'b1;
            state_next = S_REV;
          end else if (op == OP_RUN) begin
            cmd.flow_clr = 1'b1;
            state_next = S_BFS;
          end else if (op == OP_CLEAR) begin
            cmd.clear = 1'b1;
          end
        end
      end
      S_REV: begin
        cmd.add_rev = 1'b1;
        state_next = S_IDLE;
      end
      S_BFS: begin
        cmd.bfs_init = 1'b1;
        state_next = S_POP;
      end
      S_POP: begin
        if (sts.q_empty) begin
          state_next = sts.sink_found ? S_WINIT : S_DONE;
        end else begin
          cmd.pop = 1'b1;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.u_is_sink) state_next = S_WINIT;
        else if (sts.scan_done) state_next = S_POP;
        else begin
          cmd.scan = 1'b1;
          state_next = S_VIS;
        end
      end
      S_VIS: begin
        cmd.visit = 1'b1;
        state_next = S_SCAN;
      end
      S_WINIT: begin
        if (!sts.sink_found) state_next = S_DONE;
        else begin
          cmd.walk_init = 1'b1;
          state_next = S_WRD;
        end
      end
      S_WRD: begin
        if (sts.walk_at_src) state_next = S_UINIT;
        else if (sts.walk_bad) state_next = S_DONE;
        else begin
          cmd.walk_rd = 1'b1;
          state_next = S_WEV;
        end
      end
      S_WEV: begin
        cmd.walk_eval = 1'b1;
        state_next = S_WRD;
      end
      S_UINIT: begin
        cmd.walk_init = 1'b1;
        state_next = S_URD;
      end
      S_URD: begin
        if (sts.walk_at_src) state_next = S_ADD;
        else begin
          cmd.upd_rd = 1'b1;
          state_next = S_UWR;
        end
      end
      S_UWR: begin
        cmd.upd_wr = 1'b1;
        state_next = S_URD;
      end
      S_ADD: begin
        cmd.flow_add = 1'b1;
        state_next = S_BFS;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_pending <= 1'b0;
      status      <= ST_OK;
      use_flow    <= 1'b0;
    end else begin
      if (out_valid && out_ready) res_pending <= 1'b0;
      if (take && op != OP_RUN) begin
        res_pending <= 1'b1;
        use_flow    <= 1'b0;
        if (op == OP_ADD && sts.add_range) status <= ST_RANGE;
        else if (op == OP_ADD && sts.add_full) status <= ST_FULL;
        else status <= ST_OK;
      end
      if (state == S_DONE) begin
        res_pending <= 1'b1;
        use_flow    <= 1'b1;
        status      <= ST_OK;
      end
    end
  end
endmodule

>>> tb/max_flow_augmenting_path_checker.sv
`timescale 1ns / 1ps
module max_flow_augmenting_path_checker import mfap_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // operation, from_vertex, to_vertex, capacity
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,  // status, total_flow
  output int          fail_count,
  output int          pending
);
  localparam int ARC_SLOTS = 2 * MAX_EDGES_DEF;

  typedef struct packed {
    logic [1:0]           status;
    logic [FLOW_BITS-1:0] flow;
  } flow_result_t;

  flow_result_t result_q[$];

  // Shadow graph
  logic [5:0]  tail_v[ARC_SLOTS];
  logic [5:0]  head_v[ARC_SLOTS];
  logic [31:0] resid[ARC_SLOTS];
  int          arcs_used;
  logic [6:0]  vcount;

  // Search scratch
  bit          seen[MAX_VERTICES_DEF];
  int          via_arc[MAX_VERTICES_DEF];
  int          bfs_q[MAX_VERTICES_DEF];

  function automatic int live_vertices();
    int n;
    n = int'(vcount);
    if (n < 2) n = 2;
    if (n > MAX_VERTICES_DEF) n = MAX_VERTICES_DEF;
    return n;
  endfunction

  function automatic bit sink_reachable(int n);
    int hd, tl, u, v;
    for (int i = 0; i < MAX_VERTICES_DEF; i++) begin
      seen[i] = 0;
      via_arc[i] = ARC_SLOTS;
    end
    hd = 0;
    tl = 1;
    bfs_q[0] = 0;
    seen[0] = 1;
    while (hd < tl) begin
      u = bfs_q[hd];
      hd++;
      if (u == n - 1) break;
      for (int a = 0; a < arcs_used; a++) begin
        if (int'(tail_v[a]) != u) continue;
        v = int'(head_v[a]);
        if (v >= n || resid[a] == 0 || seen[v]) continue;
        seen[v] = 1;
        via_arc[v] = a;
        if (tl < MAX_VERTICES_DEF) begin
          bfs_q[tl] = v;
          tl++;
        end
      end
    end
    return seen[n - 1];
  endfunction

  function automatic logic [FLOW_BITS-1:0] augment_all(int n);
    longint sum, neck;
    int v, steps, a;
    sum = 0;
    while (sink_reachable(n)) begin
      neck = 64'h7FFF_FFFF_FFFF_FFFF;
      v = n - 1;
      steps = 0;
      while (v != 0 && steps < n) begin
        a = via_arc[v];
        if (a >= ARC_SLOTS) return (sum > FLOW_MAX) ? FLOW_MAX : sum[FLOW_BITS-1:0];
        if (longint'(resid[a]) < neck) neck = longint'(resid[a]);
        v = int'(tail_v[a]);
        steps++;
      end
      if (v != 0 || neck == 0) break;
      // push the bottleneck along the path
      v = n - 1;
      while (v != 0) begin
        a = via_arc[v];
        resid[a] = resid[a] - 32'(neck);
        resid[a ^ 1] = resid[a ^ 1] + 32'(neck);
        v = int'(tail_v[a]);
      end
      sum += neck;
    end
    return (sum > FLOW_MAX) ? FLOW_MAX : sum[FLOW_BITS-1:0];
  endfunction

  function automatic flow_result_t predict_item(logic [31:0] beat);
    flow_result_t r;
    logic [1:0] op;
    int fv, tv, n;
    op = beat[1:0];
    fv = int'(beat[7:2]);
    tv = int'(beat[13:8]);
    n = live_vertices();
    r = '0;
    r.status = ST_OK;
    if (op == OP_ADD) begin
      if (fv >= n || tv >= n) r.status = ST_RANGE;
      else if (arcs_used + 2 > ARC_SLOTS) r.status = ST_FULL;
      else begin
        tail_v[arcs_used] = 6'(fv);
        head_v[arcs_used] = 6'(tv);
        resid[arcs_used] = 32'(beat[29:14]);
        tail_v[arcs_used + 1] = 6'(tv);
        head_v[arcs_used + 1] = 6'(fv);
        resid[arcs_used + 1] = 0;
        arcs_used += 2;
      end
    end else if (op == OP_RUN) begin
      r.flow = augment_all(n);
    end else if (op == OP_CLEAR) begin
      arcs_used = 0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  assign pending = result_q.size();

  // Predict on each input beat, compare on each result beat
  always @(posedge clk) begin
    flow_result_t want;
    if (rst) begin
      result_q.delete();
      arcs_used = 0;
      vcount = 7'd64;
      fail_count = 0;
    end else begin
      if (cfg_we) vcount = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready)
        result_q.insert(result_q.size(), predict_item(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          report_mismatch("result beat count", 1, 0);
        end else begin
          want = result_q.pop_front();
          if (m_axis_tdata[1:0] != want.status)
            report_mismatch("status", int'(m_axis_tdata[1:0]), int'(want.status));
          if (m_axis_tdata[25:2] != want.flow)
            report_mismatch("total_flow", int'(m_axis_tdata[25:2]), int'(want.flow));
        end
      end
    end
  end
endmodule

>>> tb/max_flow_augmenting_path_tb.sv
`timescale 1ns / 1ps
module max_flow_augmenting_path_tb import mfap_pkg::*;;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int STALL_LIMIT = 400000;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [6:0]  cfg_wdata = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [31:0] m_axis_tdata;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          quiet_cycles = 0;

  max_flow_augmenting_path i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  max_flow_augmenting_path_checker i_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Receiver back-pressure
  always @(posedge clk)
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  // Watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("max_flow_augmenting_path_tb: errors");
      $finish;
    end
  end

  task automatic send_beat(logic [1:0] op, int fv, int tv, int cap);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {2'b00, 16'(cap), 6'(tv), 6'(fv), op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Hold off until all results are back, then write the vertex count
  task automatic set_vertices(int value);
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= 7'(value);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_graph_phase();
    int n, k;
    n = $urandom_range(2, 9);
    set_vertices(n);
    send_beat(OP_CLEAR, $urandom, $urandom, $urandom);
    k = $urandom_range(1, 10);
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(9) == 0)
        send_beat(OP_ADD, $urandom, $urandom, $urandom);
      else
        send_beat(OP_ADD, $urandom_range(n - 1), $urandom_range(n - 1),
                  ($urandom_range(3) == 0) ? $urandom : $urandom_range(20));
    end
    send_beat(OP_RUN, $urandom, $urandom, $urandom);
    // occasionally extend the graph and run again on the leftover residuals
    if ($urandom_range(2) == 0) begin
      send_beat(OP_ADD, 0, n - 1, $urandom_range(50));
      if ($urandom_range(4) == 0)
        send_beat(2'($urandom_range(3)), $urandom, $urandom, $urandom);
      send_beat(OP_RUN, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: widest graph, extremes of capacity and vertex index
    send_beat(OP_ADD, 0, 63, 16'hFFFF);
    send_beat(OP_ADD, 0, 63, 0);
    send_beat(OP_ADD, 63, 0, 16'hAAAA);
    send_beat(OP_SPARE, 6'h3F, 6'h3F, 16'hFFFF);
    send_beat(OP_RUN, 0, 0, 0);
    send_beat(OP_RUN, 0, 0, 0);
    send_beat(OP_CLEAR, 0, 0, 0);

    // Bad vertex on a small graph, then a full store
    set_vertices(2);
    send_beat(OP_ADD, 5, 1, 3);
    send_beat(OP_ADD, 0, 1, 7);
    for (int i = 1; i < MAX_EDGES_DEF; i++) send_beat(OP_ADD, 0, 1, 0);
    send_beat(OP_ADD, 1, 0, 1);
    send_beat(OP_ADD, 0, 2, 1);
    send_beat(OP_RUN, 0, 0, 0);
    send_beat(OP_CLEAR, 0, 0, 0);

    // Arcs left beyond a shrunk vertex count
    set_vertices(8);
    send_beat(OP_ADD, 0, 5, 10);
    send_beat(OP_ADD, 5, 7, 10);
    send_beat(OP_ADD, 0, 3, 4);
    send_beat(OP_ADD, 3, 7, 4);
    set_vertices(4);
    send_beat(OP_RUN, 0, 0, 0);
    set_vertices(8);
    send_beat(OP_RUN, 0, 0, 0);

    // Vertex counts outside the legal range clamp
    set_vertices(0);
    send_beat(OP_CLEAR, 0, 0, 0);
    send_beat(OP_ADD, 0, 1, 9);
    send_beat(OP_ADD, 0, 2, 9);
    send_beat(OP_RUN, 0, 0, 0);
    set_vertices(127);
    send_beat(OP_CLEAR, 0, 0, 0);
    send_beat(OP_ADD, 0, 63, 300);
    send_beat(OP_RUN, 0, 0, 0);

    // Random graphs under three idling profiles
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 23 : (p == 1) ? 81 : 0;
      recv_idle_pct = (p == 0) ? 81 : (p == 1) ? 23 : 0;
      for (int g = 0; g < 30; g++) random_graph_phase();
    end

    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("max_flow_augmenting_path_tb: clean");
    else
      $display("max_flow_augmenting_path_tb: errors");
    $finish;
  end
endmodule

>>> filelist.f
rtl/mfap_pkg.sv
rtl/mfap_datapath.sv
rtl/mfap_ctrl.sv
rtl/max_flow_augmenting_path.sv
tb/max_flow_augmenting_path_checker.sv
tb/max_flow_augmenting_path_tb.sv
